@@ hdl/key_matrix_scan_with_cooldown_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Key matrix scanner assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_SCAN_WITH_COOLDOWN_UNIT_MACROS_SVH
`define KEY_MATRIX_SCAN_WITH_COOLDOWN_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent |-> consequent, same cycle
`define KMSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// antecedent |=> consequent, next cycle
`define KMSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define KMSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define KMSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/kmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Key matrix scanner package
// Field widths, stream packing positions and transaction types.
// ----------------------------------------------------------------------------
package kmsc_pkg;

   localparam int MODE_W   = 2;
   localparam int DELTA_W  = 16;
   localparam int ROW_W    = 3;
   localparam int READ_W   = 8;
   localparam int COL_W    = 3;
   localparam int TIME_W   = 32;
   localparam int CSR_W    = 16;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   localparam logic [CSR_W-1:0] COOLDOWN_RESET = CSR_W'(50);

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_SAMPLE = 2'd1,
      MODE_SET    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [DELTA_W-1:0] delta;
      logic [ROW_W-1:0]   row;
      logic [READ_W-1:0]  first_read;
      logic [READ_W-1:0]  second_read;
      logic [COL_W-1:0]   column;
      logic               set_value;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0]  out_row;
      logic [READ_W-1:0] row_states;
      logic [READ_W-1:0] changed_mask;
      logic [TIME_W-1:0] change_time;
   } rsp_item_type;

endpackage

@@ hdl/key_matrix_scan_with_cooldown_unit.sv @@
// ----------------------------------------------------------------------------
// Key matrix scan with cooldown
// Debounces and rate-limits a button matrix, one row transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: a time tick (mode 0), a row sample with two
//   column reads (mode 1) or a direct set of one button (mode 2). mode sits in
//   req_tuser, the other fields in req_tdata. Every transaction returns exactly
//   one rsp_* transaction with the row, its states, the changed columns and
//   the elapsed time.
//   rsp_tvalid rises once the transaction has passed the input register and the
//   result register; one transaction is accepted every cycle while rsp_tready
//   is high. The first stage reads the row of change times from the time
//   memory (one row per port access), the second qualifies all columns in
//   parallel and loads the result register.
//   A write to the row being read in the same cycle is forwarded.
//   When rsp_tready is low, the result register holds, the second stage holds,
//   and req_tready drops once both are full; nothing is lost.
//   Reset clears states, elapsed time, time-memory valid bits (unwritten
//   entries read as zero) and sets the cooldown to 50. No clearing pass.
//   csr_wr_en writes the cooldown; write it only while idle.
// ----------------------------------------------------------------------------
`include "key_matrix_scan_with_cooldown_unit_macros.svh"

module key_matrix_scan_with_cooldown_unit #(
   parameter int ROWS = 8,
   parameter int COLS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: delta[15:0], row[18:16], first_read[26:19],
   //            second_read[34:27], column[37:35], set_value[38], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kmsc_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: mode[1:0]
   input  logic [kmsc_pkg::MODE_W-1:0]     req_tuser,
   // rsp_tdata: out_row[2:0], row_states[10:3], changed_mask[18:11],
   //            change_time[50:19], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kmsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [kmsc_pkg::CSR_W-1:0]      csr_wr_data
);
   import kmsc_pkg::*;

   localparam int ACT_COLS = (COLS < READ_W) ? COLS : READ_W;
   localparam int ROW_IW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   // stored state
   logic [READ_W-1:0]   state_ff   [ROWS];
   logic [ACT_COLS-1:0] lct_vld_ff [ROWS];
   logic [TIME_W-1:0]   lct_mem    [ROWS][ACT_COLS];
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [CSR_W-1:0]    cooldown_ff;

   // first stage
   logic                p1_valid_ff;
   req_item_type        p1_item_ff, req_item;
   logic [TIME_W-1:0]   lct_rd_ff  [ACT_COLS];
   logic [ACT_COLS-1:0] fwd_mask_ff, fwd_mask_in;
   logic [TIME_W-1:0]   fwd_time_ff;

   // result register
   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                req_accept, fire;
   logic                req_row_ok, row_ok, col_ok, is_tick;
   logic [ROW_IW-1:0]   req_idx, p1_idx;
   logic [READ_W-1:0]   cur_row, new_row, chg;
   logic [TIME_W-1:0]   lct_cur [ACT_COLS];

   assign req_item = '{
      mode:        req_tuser,
      delta:       req_tdata[15:0],
      row:         req_tdata[18:16],
      first_read:  req_tdata[26:19],
      second_read: req_tdata[34:27],
      column:      req_tdata[37:35],
      set_value:   req_tdata[38]
   };

   // second stage fires when the result register is free or draining
   assign fire       = p1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !p1_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   assign req_row_ok = (32'(req_item.row) < ROWS);
   assign req_idx    = req_row_ok ? ROW_IW'(req_item.row) : '0;

   assign row_ok  = (32'(p1_item_ff.row) < ROWS);
   assign col_ok  = (32'(p1_item_ff.column) < ACT_COLS);
   assign p1_idx  = row_ok ? ROW_IW'(p1_item_ff.row) : '0;
   assign is_tick = (p1_item_ff.mode == MODE_TICK);
   assign cur_row = row_ok ? state_ff[p1_idx] : '0;

   // change time per column: forwarded write, stored value, or reset zero
   always_comb begin
      for (int c = 0; c < ACT_COLS; c++) begin
         if (fwd_mask_ff[c]) begin
            lct_cur[c] = fwd_time_ff;
         end else if (lct_vld_ff[p1_idx][c]) begin
            lct_cur[c] = lct_rd_ff[c];
         end else begin
            lct_cur[c] = '0;
         end
      end
   end

   always_comb begin
      chg = '0;
      for (int c = 0; c < ACT_COLS; c++) begin
         if (row_ok && p1_item_ff.mode == MODE_SAMPLE) begin
            chg[c] = (p1_item_ff.first_read[c] != cur_row[c])
                  && (p1_item_ff.first_read[c] == p1_item_ff.second_read[c])
                  && ((lct_cur[c] + {{(TIME_W-CSR_W){1'b0}}, cooldown_ff}) < elapsed_ff);
         end else if (row_ok && col_ok && p1_item_ff.mode == MODE_SET) begin
            chg[c] = (32'(p1_item_ff.column) == c)
                  && (cur_row[c] != p1_item_ff.set_value);
         end
      end
   end

   assign new_row    = cur_row ^ chg;
   assign elapsed_in = is_tick
      ? elapsed_ff + {{(TIME_W-DELTA_W){1'b0}}, p1_item_ff.delta}
      : elapsed_ff;

   assign rsp_item_in = '{
      out_row:      p1_item_ff.row,
      row_states:   new_row,
      changed_mask: chg,
      change_time:  elapsed_in
   };

   // a row written now and read now: carry the new times into the next stage
   assign fwd_mask_in = (fire && req_idx == p1_idx) ? chg[ACT_COLS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         elapsed_ff   <= '0;
         cooldown_ff  <= COOLDOWN_RESET;
         for (int r = 0; r < ROWS; r++) begin
            state_ff[r]   <= '0;
            lct_vld_ff[r] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cooldown_ff <= csr_wr_data;
         end
         if (req_tready) begin
            p1_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            elapsed_ff <= elapsed_in;
            if (row_ok) begin
               state_ff[p1_idx]   <= new_row;
               lct_vld_ff[p1_idx] <= lct_vld_ff[p1_idx] | chg[ACT_COLS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_item_ff  <= req_item;
         fwd_mask_ff <= fwd_mask_in;
         fwd_time_ff <= elapsed_ff;
         for (int c = 0; c < ACT_COLS; c++) begin
            lct_rd_ff[c] <= lct_mem[req_idx][c];
         end
      end
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
         for (int c = 0; c < ACT_COLS; c++) begin
            if (chg[c]) begin
               lct_mem[p1_idx][c] <= elapsed_ff;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(rsp_item_type)){1'b0}},
                        rsp_item_ff.change_time, rsp_item_ff.changed_mask,
                        rsp_item_ff.row_states, rsp_item_ff.out_row};

   `KMSC_ASSERT_IMPL(a_set_one_column, clock, reset,
      fire && p1_item_ff.mode == MODE_SET, $onehot0(chg))
   `KMSC_ASSERT_IMPL(a_tick_no_change, clock, reset,
      fire && p1_item_ff.mode != MODE_SAMPLE && p1_item_ff.mode != MODE_SET, chg == '0)
   `KMSC_ASSERT_NEXT(a_time_only_on_tick, clock, reset,
      !(fire && is_tick), elapsed_ff == $past(elapsed_ff))
   `KMSC_ASSERT_IMPL(a_no_overwrite_stalled, clock, reset,
      rsp_valid_ff && !rsp_tready, !fire)

endmodule

@@ tb/key_scan_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key matrix scan checker
// Watches the request, response and CSR ports and keeps its own copy of the
// button states, change times, elapsed time and cooldown. It predicts the
// report for every accepted request and compares the responses in order.
// ----------------------------------------------------------------------------
module key_scan_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [kmsc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [kmsc_pkg::MODE_W-1:0]     req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [kmsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [kmsc_pkg::CSR_W-1:0]      csr_wr_data,
   output int                              mismatch_count,
   output int                              outstanding
);

   localparam int KEY_ROWS = 8;
   localparam int KEY_COLS = 8;

   logic [7:0]  key_state [KEY_ROWS];
   logic [31:0] change_stamp [KEY_ROWS*KEY_COLS];
   logic [31:0] elapsed;
   logic [15:0] cooldown;

   kmsc_pkg::rsp_item_type row_reports [$];
   kmsc_pkg::req_item_type req_item;
   kmsc_pkg::rsp_item_type got;
   kmsc_pkg::rsp_item_type want;
   int errors = 0;

   // Applies one request to the shadow matrix and returns the row report.
   function automatic kmsc_pkg::rsp_item_type scan_step(input kmsc_pkg::req_item_type item);
      kmsc_pkg::rsp_item_type report;
      logic [31:0] limit;
      int idx;
      report.changed_mask = '0;
      case (item.mode)
         kmsc_pkg::MODE_TICK: begin
            elapsed = elapsed + 32'(item.delta);
         end
         kmsc_pkg::MODE_SAMPLE: begin
            for (int c = 0; c < KEY_COLS; c++) begin
               idx = item.row * KEY_COLS + c;
               // sum wraps at 32 bits before the unsigned compare
               limit = change_stamp[idx] + 32'(cooldown);
               if (item.first_read[c] != key_state[item.row][c] &&
                   item.first_read[c] == item.second_read[c] && limit < elapsed) begin
                  key_state[item.row][c] = ~key_state[item.row][c];
                  change_stamp[idx] = elapsed;
                  report.changed_mask[c] = 1'b1;
               end
            end
         end
         kmsc_pkg::MODE_SET: begin
            idx = item.row * KEY_COLS + item.column;
            if (key_state[item.row][item.column] != item.set_value) begin
               key_state[item.row][item.column] = item.set_value;
               change_stamp[idx] = elapsed;
               report.changed_mask[item.column] = 1'b1;
            end
         end
         default: ;
      endcase
      report.out_row = item.row;
      report.row_states = key_state[item.row];
      report.change_time = elapsed;
      return report;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KEY_ROWS; r++) key_state[r] = '0;
         for (int i = 0; i < KEY_ROWS*KEY_COLS; i++) change_stamp[i] = '0;
         elapsed = '0;
         cooldown = kmsc_pkg::COOLDOWN_RESET;
         row_reports.delete();
      end else begin
         // responses always leave after their request, so check them first
         if (rsp_tvalid && rsp_tready) begin
            got.out_row = rsp_tdata[2:0];
            got.row_states = rsp_tdata[10:3];
            got.changed_mask = rsp_tdata[18:11];
            got.change_time = rsp_tdata[50:19];
            if (row_reports.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response: row %0d states %02h changed %02h time %08h",
                           got.out_row, got.row_states, got.changed_mask, got.change_time);
            end else begin
               want = row_reports.pop_front();
               if (got.out_row !== want.out_row || got.row_states !== want.row_states ||
                   got.changed_mask !== want.changed_mask ||
                   got.change_time !== want.change_time) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: expected row %0d states %02h changed %02h time %08h",
                              want.out_row, want.row_states, want.changed_mask,
                              want.change_time);
                     $display("          actual   row %0d states %02h changed %02h time %08h",
                              got.out_row, got.row_states, got.changed_mask, got.change_time);
                  end
               end
            end
         end
         if (csr_wr_en) cooldown = csr_wr_data;
         if (req_tvalid && req_tready) begin
            req_item.mode = req_tuser;
            req_item.delta = req_tdata[15:0];
            req_item.row = req_tdata[18:16];
            req_item.first_read = req_tdata[26:19];
            req_item.second_read = req_tdata[34:27];
            req_item.column = req_tdata[37:35];
            req_item.set_value = req_tdata[38];
            row_reports.push_back(scan_step(req_item));
         end
      end
      mismatch_count <= errors;
      outstanding <= row_reports.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key matrix scan with cooldown testbench
// Directed debounce and cooldown cases, then random ticks, row samples, direct
// sets and unused modes under several cooldown settings, with random gaps and
// response stalls.
// ----------------------------------------------------------------------------
module testbench;

   import kmsc_pkg::*;

   localparam int CYCLE_LIMIT = 100_000;
   localparam int MAX_IDLE = 17;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;

   logic        calm = 1'b0;
   int          ready_wait = 0;
   int          stall_draw;
   int          cycles = 0;
   int          mismatches;
   int          outstanding;
   int          sent = 0;
   int          random_sent = 0;
   logic [15:0] mid_cooldown;
   logic [15:0] high_cooldown;

   always #5 clock = ~clock;

   key_matrix_scan_with_cooldown_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   key_scan_checker scan_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatches),
      .outstanding    (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("key_matrix_scan_with_cooldown_unit regression: fail");
         $finish;
      end
   end

   // response side: a random stall, which may be none, after each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall_draw = calm ? 0 : $urandom_range(0, MAX_IDLE);
         ready_wait <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (ready_wait > 1) begin
         ready_wait <= ready_wait - 1;
      end else begin
         ready_wait <= 0;
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [15:0] delta,
                            input logic [2:0] row, input logic [7:0] first_read,
                            input logic [7:0] second_read, input logic [2:0] column,
                            input logic set_value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {1'b0, set_value, column, second_read, first_read, row, delta};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic random_item();
      int pick;
      int spread;
      logic [15:0] delta;
      logic [7:0] first_read;
      logic [7:0] second_read;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      spread = $urandom_range(0, 99);
      // mostly short ticks so the cooldown both blocks and releases
      if (spread < 55) delta = 16'($urandom_range(0, 40));
      else if (spread < 85) delta = 16'($urandom_range(0, 400));
      else delta = 16'($urandom);
      if (pick < 35) mode = MODE_TICK;
      else if (pick < 80) mode = MODE_SAMPLE;
      else if (pick < 95) mode = MODE_SET;
      else mode = MODE_UNUSED;
      first_read = 8'($urandom);
      second_read = ($urandom_range(0, 3) != 0) ? first_read : first_read ^ 8'($urandom);
      send_item(mode, delta, 3'($urandom), first_read, second_read, 3'($urandom),
                1'($urandom));
      random_sent++;
   endtask

   task automatic random_run(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) calm <= ($urandom_range(0, 3) == 0);
         random_item();
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cooldown(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cooldown 50 from reset, elapsed time starts at zero
      send_item(MODE_SAMPLE, 16'h0000, 3'd0, 8'hFF, 8'hFF, 3'd0, 1'b0); // blocked at start
      send_item(MODE_TICK,   16'h0000, 3'd1, 8'h00, 8'h00, 3'd0, 1'b0);
      send_item(MODE_TICK,   16'd50,   3'd0, 8'h00, 8'h00, 3'd0, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 3'd0, 8'hFF, 8'hFF, 3'd0, 1'b0); // limit == elapsed
      send_item(MODE_TICK,   16'd1,    3'd0, 8'h00, 8'h00, 3'd0, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 3'd0, 8'hFF, 8'hFF, 3'd0, 1'b0); // all columns
      send_item(MODE_SAMPLE, 16'h0000, 3'd7, 8'hFF, 8'h00, 3'd0, 1'b0); // reads disagree
      send_item(MODE_TICK,   16'hFFFF, 3'd7, 8'h00, 8'h00, 3'd0, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 3'd7, 8'hA5, 8'hA5, 3'd0, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 3'd0, 8'h00, 8'h00, 3'd0, 1'b0); // release
      send_item(MODE_SAMPLE, 16'h0000, 3'd0, 8'hFF, 8'hFF, 3'd0, 1'b0); // still cooling
      send_item(MODE_SET,    16'h0000, 3'd0, 8'h00, 8'h00, 3'd0, 1'b1); // ignores cooldown
      send_item(MODE_SET,    16'h0000, 3'd0, 8'h00, 8'h00, 3'd0, 1'b1); // same value
      send_item(MODE_SET,    16'h0000, 3'd7, 8'h00, 8'h00, 3'd7, 1'b0);
      send_item(MODE_SET,    16'h0000, 3'd3, 8'h00, 8'h00, 3'd7, 1'b1);
      send_item(MODE_SET,    16'h0000, 3'd3, 8'h00, 8'h00, 3'd0, 1'b1);
      send_item(MODE_UNUSED, 16'hFFFF, 3'd7, 8'hFF, 8'hFF, 3'd7, 1'b1);
      send_item(MODE_UNUSED, 16'h0000, 3'd0, 8'h00, 8'h00, 3'd0, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 3'd5, 8'h0F, 8'h3C, 3'd0, 1'b0);
      send_item(MODE_TICK,   16'h5A5A, 3'd3, 8'h00, 8'h00, 3'd0, 1'b0);
      send_item(MODE_SAMPLE, 16'h0000, 3'd3, 8'h00, 8'h00, 3'd0, 1'b0);
      settle();

      random_run(200);
      settle();
      write_cooldown(16'h0000);
      random_run(130);
      settle();
      write_cooldown(16'hFFFF);
      random_run(130);
      settle();
      mid_cooldown = 16'($urandom_range(1, 65534));
      write_cooldown(mid_cooldown);
      random_run(70);
      settle();

      // a long cooldown with mixed traffic
      high_cooldown = 16'($urandom_range(2000, 65535));
      write_cooldown(high_cooldown);
      random_run(80);
      settle();

      $display("%0d transactions, %0d random, with random source gaps and sink stalls",
               sent, random_sent);
      $display("cooldown settings used: 50, 0, 65535, %0d, %0d", mid_cooldown, high_cooldown);
      if (mismatches == 0) begin
         $display("key_matrix_scan_with_cooldown_unit regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("key_matrix_scan_with_cooldown_unit regression: fail");
      end
      $finish;
   end

endmodule
